[rtl/random_dropout_hold_mixer_core_defines.svh]
// Assertion macros for the checker of the dropout mixer core.
`ifndef RANDOM_DROPOUT_HOLD_MIXER_CORE_DEFINES_SVH
`define RANDOM_DROPOUT_HOLD_MIXER_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define RDHM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define RDHM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define RDHM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/rdhm_pkg.sv]
// Shared types and constants of the dropout hold mixer.
`default_nettype none

package rdhm_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] REG_ENABLE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CH_COUNT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_LEN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MIX_LEVEL  = 3'd4;

   localparam int CH_CNT_W   = 2;
   localparam int THRESH_W   = 16;
   localparam int HOLD_REG_W = 16;
   localparam int MIX_W      = 17;

   // random generator
   localparam int          RNG_W    = 32;
   localparam logic [31:0] LCG_MUL  = 32'd1664525;
   localparam logic [31:0] LCG_ADD  = 32'd1013904223;
   localparam logic [31:0] RNG_SEED = 32'h9E37_79B9;
   localparam int          RND_LSB  = 8;

   localparam logic [MIX_W-1:0] MIX_ONE = 17'h1_0000;
   localparam int               MIX_SHIFT = 16;

   // second operand of the shared multiplier: LCG factor or mix level, signed
   localparam int MUL_B_W = 22;

   typedef struct packed {
      logic                  enable;
      logic                  clear;
      logic [CH_CNT_W-1:0]   channel_count;
      logic [THRESH_W-1:0]   drop_threshold;
      logic [HOLD_REG_W-1:0] hold_length;
      logic [MIX_W-1:0]      mix_level;
   } cfg_type;

endpackage

`default_nettype wire

[rtl/rdhm_req_if.sv]
// Input channel carrying one dry stereo frame per item.
`default_nettype none

interface rdhm_req_if #(
   parameter int SAMPLE_WIDTH = 24
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] left_in;
   logic signed [SAMPLE_WIDTH-1:0] right_in;

   modport source (output valid, output left_in, output right_in, input ready);
   modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

`default_nettype wire

[rtl/rdhm_rsp_if.sv]
// Result channel carrying one mixed stereo frame per item.
`default_nettype none

interface rdhm_rsp_if #(
   parameter int SAMPLE_WIDTH = 24
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] left_out;
   logic signed [SAMPLE_WIDTH-1:0] right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

[rtl/rdhm_mul.sv]
// Shared signed multiplier with a registered product.
`default_nettype none

module rdhm_mul #(
   parameter int A_W = 33,
   parameter int B_W = 22
) (
   input  wire logic                     clock,
   input  wire logic signed [A_W-1:0]    op_a,
   input  wire logic signed [B_W-1:0]    op_b,
   output logic signed [A_W+B_W-1:0]     product
);

   logic signed [A_W+B_W-1:0] product_ff;
   logic signed [A_W+B_W-1:0] product_in;

   assign product_in = op_a * op_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

[rtl/rdhm_csr.sv]
// Configuration registers and the state clear strobe.
`default_nettype none

module rdhm_csr import rdhm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type                    cfg
);

   logic                  enable_ff,    enable_in;
   logic [CH_CNT_W-1:0]   ch_count_ff,  ch_count_in;
   logic [THRESH_W-1:0]   threshold_ff, threshold_in;
   logic [HOLD_REG_W-1:0] hold_len_ff,  hold_len_in;
   logic [MIX_W-1:0]      mix_ff,       mix_in;
   logic                  clear;

   always_comb begin
      enable_in    = enable_ff;
      ch_count_in  = ch_count_ff;
      threshold_in = threshold_ff;
      hold_len_in  = hold_len_ff;
      mix_in       = mix_ff;
      clear        = 1'b0;
      if (csr_we) begin
         case (csr_index)
            REG_ENABLE: begin
               enable_in = csr_data[0];
               clear     = ~csr_data[0];
            end
            REG_CH_COUNT:  ch_count_in  = csr_data[CH_CNT_W-1:0];
            REG_THRESHOLD: threshold_in = csr_data[THRESH_W-1:0];
            REG_HOLD_LEN:  hold_len_in  = csr_data[HOLD_REG_W-1:0];
            REG_MIX_LEVEL: mix_in       = csr_data[MIX_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         ch_count_ff  <= CH_CNT_W'(2);
         threshold_ff <= '0;
         hold_len_ff  <= HOLD_REG_W'(1);
         mix_ff       <= '0;
      end else begin
         enable_ff    <= enable_in;
         ch_count_ff  <= ch_count_in;
         threshold_ff <= threshold_in;
         hold_len_ff  <= hold_len_in;
         mix_ff       <= mix_in;
      end
   end

   assign cfg.enable         = enable_ff;
   assign cfg.clear          = clear;
   assign cfg.channel_count  = ch_count_ff;
   assign cfg.drop_threshold = threshold_ff;
   assign cfg.hold_length    = hold_len_ff;
   assign cfg.mix_level      = mix_ff;

endmodule

`default_nettype wire

[rtl/rdhm_engine.sv]
// Per-channel sequencer around the shared multiplier: LCG step, drop decision, mix.
`default_nettype none

module rdhm_engine import rdhm_pkg::*; #(
   parameter int SAMPLE_WIDTH = 24,
   parameter int HOLD_WIDTH   = 16,
   parameter int CHANNELS     = 2
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire cfg_type                        cfg,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_left,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_right,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_left,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_right
);

   localparam int SW       = SAMPLE_WIDTH;
   localparam int HW       = HOLD_WIDTH;
   localparam int MUL_A_W  = (SW + 1 > RNG_W + 1) ? SW + 1 : RNG_W + 1;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int CH_W     = 2;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHK,
      S_LCG,
      S_MIX_MUL,
      S_MIX,
      S_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [CH_W-1:0]           ch_ff, ch_in;
   logic signed [SW-1:0]      dry_ff [2];
   logic signed [SW-1:0]      dry_in [2];
   logic signed [SW-1:0]      res_ff [2];
   logic signed [SW-1:0]      res_in [2];
   logic [RNG_W-1:0]          rng_ff, rng_in;
   logic [HW-1:0]             hold_ff [CHANNELS];
   logic [HW-1:0]             hold_in [CHANNELS];
   logic signed [SW-1:0]      held_ff [CHANNELS];
   logic signed [SW-1:0]      held_in [CHANNELS];
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]      rsp_left_ff, rsp_left_in;
   logic signed [SW-1:0]      rsp_right_ff, rsp_right_in;

   logic [CH_IDX_W-1:0]       ci;
   logic                      di;
   logic [CH_W-1:0]           active;
   logic [HW-1:0]             hold_ext;
   logic [HW-1:0]             hold_len;
   logic [MIX_W-1:0]          mix_sat;
   logic signed [SW:0]        diff;
   logic [RNG_W-1:0]          rng_next;
   logic [THRESH_W-1:0]       rnd;
   logic signed [MUL_A_W-1:0] op_a;
   logic signed [MUL_B_W-1:0] op_b;
   logic signed [PROD_W-1:0]  product;
   logic                      out_free;

   rdhm_mul #(
      .A_W(MUL_A_W),
      .B_W(MUL_B_W)
   ) u_mul (
      .clock  (clock),
      .op_a   (op_a),
      .op_b   (op_b),
      .product(product)
   );

   assign ci = ch_ff[CH_IDX_W-1:0];
   assign di = ch_ff[0];

   assign active   = (cfg.channel_count > CH_W'(CHANNELS)) ? CH_W'(CHANNELS)
                                                           : cfg.channel_count;
   assign hold_ext = HW'(cfg.hold_length);
   assign hold_len = (hold_ext == '0) ? HW'(1) : hold_ext;
   assign mix_sat  = cfg.mix_level[MIX_W-1] ? MIX_ONE : cfg.mix_level;

   assign diff     = {held_ff[ci][SW-1], held_ff[ci]} - {dry_ff[di][SW-1], dry_ff[di]};
   assign rng_next = product[RNG_W-1:0] + LCG_ADD;
   assign rnd      = rng_next[RND_LSB +: THRESH_W];

   // multiplier runs the LCG unless a mix product is being issued
   always_comb begin
      if (state_ff == S_MIX_MUL) begin
         op_a = MUL_A_W'(diff);
         op_b = MUL_B_W'({1'b0, mix_sat});
      end else begin
         op_a = MUL_A_W'({1'b0, rng_ff});
         op_b = MUL_B_W'(LCG_MUL);
      end
   end

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      dry_in       = dry_ff;
      res_in       = res_ff;
      rng_in       = rng_ff;
      hold_in      = hold_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dry_in[0] = req_left;
               dry_in[1] = req_right;
               res_in[0] = req_left;
               res_in[1] = req_right;
               ch_in     = '0;
               state_in  = cfg.enable ? S_CHK : S_DONE;
            end
         end
         S_CHK: begin
            if (ch_ff >= active) begin
               state_in = S_DONE;
            end else if (hold_ff[ci] == '0) begin
               state_in = S_LCG;
            end else begin
               state_in = S_MIX_MUL;
            end
         end
         S_LCG: begin
            rng_in = rng_next;
            if (rnd < cfg.drop_threshold) begin
               held_in[ci] = '0;
               hold_in[ci] = hold_len;
            end else begin
               held_in[ci] = dry_ff[di];
               hold_in[ci] = HW'(1);
            end
            state_in = S_MIX_MUL;
         end
         S_MIX_MUL: begin
            state_in = S_MIX;
         end
         S_MIX: begin
            // floor((held - dry) * mix / 2^16); the sum stays in range
            res_in[di]  = dry_ff[di] + product[MIX_SHIFT +: SW];
            hold_in[ci] = hold_ff[ci] - HW'(1);
            ch_in       = ch_ff + CH_W'(1);
            state_in    = S_CHK;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = res_ff[0];
               rsp_right_in = res_ff[1];
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (cfg.clear) begin
         rng_in = RNG_SEED;
         for (int i = 0; i < CHANNELS; i++) begin
            hold_in[i] = '0;
            held_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rng_ff       <= RNG_SEED;
         for (int i = 0; i < CHANNELS; i++) begin
            hold_ff[i] <= '0;
            held_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rng_ff       <= rng_in;
         hold_ff      <= hold_in;
         held_ff      <= held_in;
      end
      ch_ff        <= ch_in;
      dry_ff       <= dry_in;
      res_ff       <= res_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_left  = rsp_left_ff;
   assign rsp_right = rsp_right_ff;

endmodule

`default_nettype wire

[rtl/random_dropout_hold_mixer_core.sv]
// Sequencing: the active channels are processed in turn, each with an LCG step, drop
//   decision and mix; a channel whose hold is still running skips the LCG step.
// Items: a new item is accepted only once the last result is registered; every LCG
//   step and mix product goes through the one shared multiplier.
// Reset: synchronous, active high; registers to defaults, LCG to its seed, holds clear.
`default_nettype none

module random_dropout_hold_mixer_core import rdhm_pkg::*; #(
   parameter int SAMPLE_WIDTH = 24,
   parameter int HOLD_WIDTH   = 16,
   parameter int CHANNELS     = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   rdhm_req_if.sink                   req_chan,
   rdhm_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg;

   rdhm_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .cfg      (cfg)
   );

   rdhm_engine #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .HOLD_WIDTH  (HOLD_WIDTH),
      .CHANNELS    (CHANNELS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .req_left (req_chan.left_in),
      .req_right(req_chan.right_in),
      .rsp_valid(rsp_chan.valid),
      .rsp_ready(rsp_chan.ready),
      .rsp_left (rsp_chan.left_out),
      .rsp_right(rsp_chan.right_out)
   );

endmodule

`default_nettype wire

[rtl/rdhm_checker.sv]
// Port-level checker for the dropout mixer core, bound to the top level.
`default_nettype none
`include "random_dropout_hold_mixer_core_defines.svh"

module rdhm_checker #(
   parameter int SAMPLE_WIDTH = 24
) (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic [SAMPLE_WIDTH-1:0] rsp_left,
   input wire logic [SAMPLE_WIDTH-1:0] rsp_right
);

   // an accepted item makes the block busy, so ready goes low
   `RDHM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready stayed high after an item was accepted")

   // reset leaves the block idle with no result pending
   `RDHM_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, req_ready && !rsp_valid, "block not idle after reset")

   `RDHM_ASSERT_NEXT(a_rsp_valid_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

   `RDHM_ASSERT_NOW(a_rsp_data_hold, clock, reset, $past(rsp_valid && !rsp_ready) && !$past(reset), $stable(rsp_left) && $stable(rsp_right), "stalled result changed")

endmodule

bind random_dropout_hold_mixer_core rdhm_checker #(
   .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_rdhm_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_left (rsp_chan.left_out),
   .rsp_right(rsp_chan.right_out)
);

`default_nettype wire
